// ===== sv/vof_ftf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package vof_ftf_pkg;

	localparam int CSF_QW      = 33;   // quotient bits of the harmonic mean
	localparam int CSF_NMUL    = 6;    // chained Q16.16 multiply stages
	localparam int CSF_LATENCY = 49;   // accept edge to result sample edge
	localparam int CSF_AW      = 5;

	typedef enum logic [2:0] {
		REG_TENSION   = 3'd0,
		REG_INV_DX    = 3'd1,
		REG_INV_DY    = 3'd2,
		REG_INV_DZ    = 3'd3,
		REG_INV_GAP   = 3'd4,
		REG_INV_MEAN  = 3'd5,
		REG_WEIGHTING = 3'd6
	} csf_reg_t;

	typedef enum logic [1:0] {
		ST_NONE  = 2'd0,
		ST_VALID1 = 2'd1,
		ST_VALID2 = 2'd2,
		ST_OTHER = 2'd3
	} csf_status_t;

	typedef enum logic [1:0] {
		AX_X = 2'd0,
		AX_Y = 2'd1,
		AX_Z = 2'd2
	} csf_axis_t;

	typedef struct packed {
		logic [1:0]         axis;
		logic signed [31:0] curvature_lower;
		logic signed [31:0] curvature_upper;
		logic [1:0]         status_lower;
		logic [1:0]         status_upper;
		logic [15:0]        phi_lower;
		logic [15:0]        phi_upper;
		logic [31:0]        density_lower;
		logic [31:0]        density_upper;
	} csf_in_t;

	typedef struct packed {
		logic signed [31:0] face_force;
		logic               interface_active;
		logic               saturated;
	} csf_out_t;

	typedef struct packed {
		logic [31:0]        tension_coefficient;
		logic [31:0]        inv_spacing_x;
		logic [31:0]        inv_spacing_y;
		logic [31:0]        inv_spacing_z;
		logic signed [31:0] inv_density_gap;
		logic [31:0]        inv_density_mean;
		logic               density_weighting;
	} csf_cfg_t;

	typedef struct packed {
		logic        active;
		logic        dens;
		logic        neg;
		logic        diff_neg;
		logic [1:0]  axis;
		logic [32:0] diffb;
		logic [31:0] avg;
	} csf_mul_side_t;

	typedef struct packed {
		logic          harm;
		logic          harm_neg;
		logic [32:0]   kmag;
		logic          kneg;
		csf_mul_side_t mul;
	} csf_front_t;

endpackage
`default_nettype wire

// ===== sv/vof_ftf_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vof_ftf_cfg
	import vof_ftf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CSF_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output csf_cfg_t               cfg
);

	csf_cfg_t cfg_q;
	logic     wr;
	csf_reg_t idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = csf_reg_t'(paddr[4:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tension_coefficient <= '0;
			cfg_q.inv_spacing_x       <= 32'd65536;
			cfg_q.inv_spacing_y       <= 32'd65536;
			cfg_q.inv_spacing_z       <= 32'd65536;
			cfg_q.inv_density_gap     <= '0;
			cfg_q.inv_density_mean    <= '0;
			cfg_q.density_weighting   <= 1'b0;
		end else if (wr) begin
			case (idx)
				REG_TENSION:   cfg_q.tension_coefficient <= pwdata;
				REG_INV_DX:    cfg_q.inv_spacing_x       <= pwdata;
				REG_INV_DY:    cfg_q.inv_spacing_y       <= pwdata;
				REG_INV_DZ:    cfg_q.inv_spacing_z       <= pwdata;
				REG_INV_GAP:   cfg_q.inv_density_gap     <= pwdata;
				REG_INV_MEAN:  cfg_q.inv_density_mean    <= pwdata;
				REG_WEIGHTING: cfg_q.density_weighting   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TENSION:   prdata = cfg_q.tension_coefficient;
			REG_INV_DX:    prdata = cfg_q.inv_spacing_x;
			REG_INV_DY:    prdata = cfg_q.inv_spacing_y;
			REG_INV_DZ:    prdata = cfg_q.inv_spacing_z;
			REG_INV_GAP:   prdata = cfg_q.inv_density_gap;
			REG_INV_MEAN:  prdata = cfg_q.inv_density_mean;
			REG_WEIGHTING: prdata = {31'd0, cfg_q.density_weighting};
			default:       prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/vof_ftf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vof_ftf_div
	import vof_ftf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [63:0] num,
	input  wire logic [32:0] den,
	input  csf_front_t       side_in,
	output logic             out_valid,
	output logic [CSF_QW-1:0] quo,
	output csf_front_t       side_out
);

	// one quotient bit per stage, most significant first
	logic [63:0]       rem_s  [CSF_QW];
	logic [CSF_QW-1:0] quo_s  [CSF_QW];
	logic [32:0]       den_s  [CSF_QW];
	csf_front_t        side_s [CSF_QW];
	logic              v_s    [CSF_QW];

	for (genvar g = 0; g < CSF_QW; g++) begin : g_stage
		logic [63:0]       rem_c;
		logic [CSF_QW-1:0] quo_c;
		logic [32:0]       den_c;
		csf_front_t        side_c;
		logic              v_c;
		logic [65:0]       shd;
		logic [65:0]       trial;

		if (g == 0) begin : g_first
			assign rem_c  = num;
			assign quo_c  = '0;
			assign den_c  = den;
			assign side_c = side_in;
			assign v_c    = in_valid;
		end else begin : g_next
			assign rem_c  = rem_s[g-1];
			assign quo_c  = quo_s[g-1];
			assign den_c  = den_s[g-1];
			assign side_c = side_s[g-1];
			assign v_c    = v_s[g-1];
		end

		assign shd   = {33'd0, den_c} << (CSF_QW - 1 - g);
		assign trial = {2'b00, rem_c} - shd;

		always_ff @(posedge clk) begin
			rem_s[g]  <= trial[65] ? rem_c : trial[63:0];
			quo_s[g]  <= {quo_c[CSF_QW-2:0], ~trial[65]};
			den_s[g]  <= den_c;
			side_s[g] <= side_c;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else begin
				v_s[g] <= v_c;
			end
		end
	end

	assign out_valid = v_s[CSF_QW-1];
	assign quo       = quo_s[CSF_QW-1];
	assign side_out  = side_s[CSF_QW-1];

endmodule
`default_nettype wire

// ===== sv/vof_ftf_qmul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module vof_ftf_qmul
	import vof_ftf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        bypass,
	input  wire logic [63:0] a,
	input  wire logic [32:0] b,
	input  wire logic        clip_in,
	input  csf_mul_side_t    side_in,
	output logic             out_valid,
	output logic [63:0]      m,
	output logic             clip,
	output csf_mul_side_t    side_out
);

	logic [64:0]   pl_s1, ph_s1;
	logic [63:0]   a_s1;
	logic          byp_s1, clip_s1, v_s1;
	csf_mul_side_t side_s1;
	logic [96:0]   full;
	logic          ovf;
	logic [63:0]   m_s2;
	logic          clip_s2, v_s2;
	csf_mul_side_t side_s2;

	// split the wide operand into two 32 by 33 partial products
	always_ff @(posedge clk) begin
		pl_s1   <= {33'd0, a[31:0]} * {32'd0, b};
		ph_s1   <= {33'd0, a[63:32]} * {32'd0, b};
		a_s1    <= a;
		byp_s1  <= bypass;
		clip_s1 <= clip_in;
		side_s1 <= side_in;
	end

	assign full = {ph_s1, 32'd0} + {32'd0, pl_s1};
	assign ovf  = |full[96:80];

	always_ff @(posedge clk) begin
		m_s2    <= byp_s1 ? a_s1 : (ovf ? '1 : full[79:16]);
		clip_s2 <= clip_s1 | (~byp_s1 & ovf);
		side_s2 <= side_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	assign out_valid = v_s2;
	assign m         = m_s2;
	assign clip      = clip_s2;
	assign side_out  = side_s2;

endmodule
`default_nettype wire

// ===== sv/vof_face_tension_force_top.sv =====
`timescale 1ns / 1ps
// Throughput: one face per cycle; busy stays low and start may be held high.
// Depth is set by the 33-stage harmonic-mean divider and six two-stage multipliers.
// Reset clears all valid bits and loads the register defaults; no result is lost
// as the receiver cannot stall.
`default_nettype none
module vof_face_tension_force_top
	import vof_ftf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  csf_in_t                in_item,
	output logic                   done,
	output csf_out_t               out_item,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CSF_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	csf_cfg_t cfg;

	vof_ftf_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	assign busy = 1'b0;

	// front decode
	logic [31:0] ma, mb, amag, gmag;
	logic [32:0] ksum, kabs, dd, avgsum;
	logic [16:0] dph;
	logic [15:0] phmag;
	logic [31:0] ddmag;
	logic        mean, sel_lo, sel_up, active;
	csf_front_t  front;
	logic [1:0]  sl, su;

	assign sl     = in_item.status_lower;
	assign su     = in_item.status_upper;
	assign ma     = in_item.curvature_lower[31] ? (~in_item.curvature_lower + 32'd1)
	                                            : in_item.curvature_lower;
	assign mb     = in_item.curvature_upper[31] ? (~in_item.curvature_upper + 32'd1)
	                                            : in_item.curvature_upper;
	assign ksum   = {in_item.curvature_lower[31], in_item.curvature_lower}
	              + {in_item.curvature_upper[31], in_item.curvature_upper};
	assign kabs   = ksum[32] ? (~ksum + 33'd1) : ksum;
	assign amag   = kabs[32:1];
	assign dph    = {1'b0, in_item.phi_upper} - {1'b0, in_item.phi_lower};
	assign phmag  = dph[16] ? 16'(~dph + 17'd1) : dph[15:0];
	assign dd     = {1'b0, in_item.density_upper} - {1'b0, in_item.density_lower};
	assign ddmag  = dd[32] ? 32'(~dd + 33'd1) : dd[31:0];
	assign avgsum = {1'b0, in_item.density_lower} + {1'b0, in_item.density_upper};
	assign gmag   = cfg.inv_density_gap[31] ? (~cfg.inv_density_gap + 32'd1)
	                                        : cfg.inv_density_gap;

	assign mean   = (sl == ST_VALID1 && su == ST_VALID1) || (sl == ST_VALID2 && su == ST_VALID2);
	assign sel_lo = (sl == ST_VALID1 && (su == ST_VALID2 || su == ST_NONE))
	              || (sl == ST_VALID2 && su == ST_NONE);
	assign sel_up = (su == ST_VALID1 && (sl == ST_VALID2 || sl == ST_NONE))
	              || (su == ST_VALID2 && sl == ST_NONE);
	assign active = sl == ST_VALID1 || sl == ST_VALID2 || su == ST_VALID1 || su == ST_VALID2;

	always_comb begin
		front.harm     = mean && (in_item.curvature_lower[31] == in_item.curvature_upper[31])
		               && (in_item.curvature_lower != '0) && (in_item.curvature_upper != '0);
		front.harm_neg = in_item.curvature_lower[31];
		if (mean) begin
			front.kmag = {1'b0, amag};
			front.kneg = ksum[32];
		end else if (sel_lo) begin
			front.kmag = {1'b0, ma};
			front.kneg = in_item.curvature_lower[31];
		end else if (sel_up) begin
			front.kmag = {1'b0, mb};
			front.kneg = in_item.curvature_upper[31];
		end else begin
			front.kmag = '0;
			front.kneg = 1'b0;
		end
		front.mul.active = active;
		front.mul.dens   = cfg.density_weighting;
		front.mul.neg    = 1'b0;
		front.mul.axis   = in_item.axis;
		front.mul.avg    = avgsum[32:1];
		if (cfg.density_weighting) begin
			front.mul.diffb    = {1'b0, ddmag};
			front.mul.diff_neg = dd[32];
		end else begin
			front.mul.diffb    = {16'd0, phmag, 1'b0};
			front.mul.diff_neg = dph[16];
		end
	end

	logic [31:0] ma_s1, mb_s1;
	logic [32:0] den_s1, den_s2;
	csf_front_t  front_s1, front_s2;
	logic [63:0] prod_s2;
	logic        v_s1, v_s2;

	always_ff @(posedge clk) begin
		ma_s1    <= ma;
		mb_s1    <= mb;
		den_s1   <= {1'b0, ma} + {1'b0, mb};
		front_s1 <= front;
		prod_s2  <= {32'd0, ma_s1} * {32'd0, mb_s1};
		den_s2   <= den_s1;
		front_s2 <= front_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	logic              dv;
	logic [CSF_QW-1:0] dq;
	csf_front_t        dside;

	vof_ftf_div u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s2), .num({prod_s2[62:0], 1'b0}),
		.den(den_s2), .side_in(front_s2), .out_valid(dv), .quo(dq), .side_out(dside)
	);

	// face curvature and overall sign
	logic [32:0]   kmag_s3;
	csf_mul_side_t side_c;
	csf_mul_side_t side_s3;
	logic          v_s3;

	always_comb begin
		side_c     = dside.mul;
		side_c.neg = (dside.harm ? dside.harm_neg : dside.kneg) ^ dside.mul.diff_neg
		           ^ (dside.mul.dens & cfg.inv_density_gap[31]);
	end

	always_ff @(posedge clk) begin
		kmag_s3 <= dside.harm ? dq : dside.kmag;
		side_s3 <= side_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= dv;
		end
	end

	logic [63:0]   mv [CSF_NMUL+1];
	logic          cv [CSF_NMUL+1];
	logic          vv [CSF_NMUL+1];
	csf_mul_side_t sv [CSF_NMUL+1];

	assign mv[0] = {32'd0, cfg.tension_coefficient};
	assign cv[0] = 1'b0;
	assign vv[0] = v_s3;
	assign sv[0] = side_s3;

	for (genvar j = 0; j < CSF_NMUL; j++) begin : g_mul
		logic [32:0] bop;
		logic        byp;

		if (j == 0) begin : g_k
			assign bop = kmag_s3;
			assign byp = 1'b0;
		end else if (j == 1) begin : g_diff
			assign bop = sv[j].diffb;
			assign byp = 1'b0;
		end else if (j == 2) begin : g_inv
			assign bop = (sv[j].axis == AX_X) ? {1'b0, cfg.inv_spacing_x}
			           : (sv[j].axis == AX_Y) ? {1'b0, cfg.inv_spacing_y}
			           : {1'b0, cfg.inv_spacing_z};
			assign byp = 1'b0;
		end else if (j == 3) begin : g_gap
			assign bop = {1'b0, gmag};
			assign byp = ~sv[j].dens;
		end else if (j == 4) begin : g_avg
			assign bop = {1'b0, sv[j].avg};
			assign byp = ~sv[j].dens;
		end else begin : g_mean
			assign bop = {1'b0, cfg.inv_density_mean};
			assign byp = ~sv[j].dens;
		end

		vof_ftf_qmul u_qmul (
			.clk(clk), .arst_n(arst_n), .in_valid(vv[j]), .bypass(byp), .a(mv[j]),
			.b(bop), .clip_in(cv[j]), .side_in(sv[j]), .out_valid(vv[j+1]),
			.m(mv[j+1]), .clip(cv[j+1]), .side_out(sv[j+1])
		);
	end

	// final saturation to signed Q16.16
	logic [63:0]   mf;
	csf_mul_side_t sf;
	logic          pos_ovf, neg_ovf;
	csf_out_t      res, out_q;
	logic          done_q;

	assign mf      = mv[CSF_NMUL];
	assign sf      = sv[CSF_NMUL];
	assign pos_ovf = mf > 64'h0000_0000_7FFF_FFFF;
	assign neg_ovf = mf > 64'h0000_0000_8000_0000;

	always_comb begin
		res.interface_active = sf.active;
		if (!sf.active || mf == '0) begin
			res.face_force = '0;
			res.saturated  = sf.active & cv[CSF_NMUL];
		end else if (!sf.neg) begin
			res.face_force = pos_ovf ? 32'h7FFF_FFFF : mf[31:0];
			res.saturated  = cv[CSF_NMUL] | pos_ovf;
		end else begin
			res.face_force = neg_ovf ? 32'h8000_0000 : (~mf[31:0] + 32'd1);
			res.saturated  = cv[CSF_NMUL] | neg_ovf;
		end
	end

	always_ff @(posedge clk) begin
		out_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vv[CSF_NMUL];
		end
	end

	assign done     = done_q;
	assign out_item = out_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##CSF_LATENCY done)
		else $error("accepted face produced no result on time");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, CSF_LATENCY))
		else $error("result without an accepted face");

	a_idle_face: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_item.interface_active |-> out_item.face_force == '0 && !out_item.saturated)
		else $error("inactive face carries a force");

endmodule
`default_nettype wire
